/* src/mbx_pkg.sv */
// ----------------------------------------------------------------------------
// Mailbox matcher package
// Shared types, codes and the header check for the mailbox slot matcher.
// ----------------------------------------------------------------------------
package mbx_pkg;

  localparam int NUM_PROCS_DEF = 8;

  localparam int RANK_W  = 3;
  localparam int TAG_W   = 16;
  localparam int TYPE_W  = 8;
  localparam int COMM_W  = 8;
  localparam int COUNT_W = 16;
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 4;
  localparam int NREGS   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_APP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_MASK = 1'b1;

  localparam logic [SIZE_W-1:0] APP_SIZE_RST = 4'd8;
  localparam logic [TAG_W-1:0]  TAG_MASK_RST = 16'h8000;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PENDING = 3'd1,
    ST_BUSY    = 3'd2,
    ST_TYPE    = 3'd3,
    ST_TAG     = 3'd4,
    ST_COMM    = 3'd5,
    ST_COUNT   = 3'd6
  } status_e;

  // Work classes decided by the front end
  typedef enum logic [2:0] {
    OP_SEND,
    OP_BUSY,
    OP_PEND,
    OP_DIRECT,
    OP_SCAN_M,
    OP_SCAN_S
  } op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOK,
    B_CHECK
  } back_state_e;

  typedef struct packed {
    op_e                 op;
    logic [RANK_W-1:0]   own;
    logic [RANK_W-1:0]   peer;
    logic [SIZE_W-1:0]   scan_n;
    logic                any_tag;
    logic [TAG_W-1:0]    tag;
    logic [TYPE_W-1:0]   dtype;
    logic [COMM_W-1:0]   comm;
    logic [COUNT_W-1:0]  count;
    logic [ADDR_W-1:0]   addr;
  } cmd_t;

  typedef struct packed {
    logic [RANK_W-1:0]   source;
    logic [TYPE_W-1:0]   dtype;
    logic [COMM_W-1:0]   comm;
    logic [TAG_W-1:0]    tag;
    logic [COUNT_W-1:0]  count;
    logic [ADDR_W-1:0]   addr;
  } entry_t;

  // Header compare: first mismatch wins
  function automatic status_e mbx_check(entry_t e, cmd_t c, logic [TAG_W-1:0] mask);
    status_e st;
    st = ST_OK;
    if (e.dtype != c.dtype) begin
      st = ST_TYPE;
    end else if (c.any_tag ? ((e.tag & mask) == '0) : (e.tag != c.tag)) begin
      st = ST_TAG;
    end else if (e.comm != c.comm) begin
      st = ST_COMM;
    end else if (e.count != c.count) begin
      st = ST_COUNT;
    end
    return st;
  endfunction

endpackage

/* src/mbx_req_if.sv */
// ----------------------------------------------------------------------------
// Mailbox request channel
// Valid/ready channel carrying one send or receive request.
// ----------------------------------------------------------------------------
interface mbx_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  own_rank;
  logic [2:0]  peer_rank;
  logic        any_source;
  logic [15:0] msg_tag;
  logic        any_tag;
  logic [7:0]  data_type;
  logic [7:0]  communicator;
  logic [15:0] elem_count;
  logic [31:0] buffer_addr;

  modport source (output valid, cmd, own_rank, peer_rank, any_source, msg_tag, any_tag,
                  data_type, communicator, elem_count, buffer_addr, input ready);
  modport sink (input valid, cmd, own_rank, peer_rank, any_source, msg_tag, any_tag,
                data_type, communicator, elem_count, buffer_addr, output ready);
endinterface

/* src/mbx_rsp_if.sv */
// ----------------------------------------------------------------------------
// Mailbox response channel
// Valid/ready channel carrying one status result.
// ----------------------------------------------------------------------------
interface mbx_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status_code;
  logic [2:0]  source_rank;
  logic [15:0] matched_tag;
  logic [31:0] message_addr;

  modport source (output valid, status_code, source_rank, matched_tag, message_addr,
                  input ready);
  modport sink (input valid, status_code, source_rank, matched_tag, message_addr,
                output ready);
endinterface

/* src/mbx_front.sv */
// ----------------------------------------------------------------------------
// Mailbox front end
// Accepts requests and classifies them into work for the back end.
// ----------------------------------------------------------------------------
module mbx_front
  import mbx_pkg::*;
#(
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  mbx_req_if.sink          req,
  input  logic [SIZE_W-1:0] app_size_i,
  input  logic             q_full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic              own_ok, peer_ok;
  logic [SIZE_W-1:0] scan_n;

  assign req.ready = !q_full_i;
  assign push_o    = req.valid && !q_full_i;

  assign own_ok  = int'(req.own_rank) < NUM_PROCS;
  assign peer_ok = int'(req.peer_rank) < NUM_PROCS;
  assign scan_n  = (int'(app_size_i) > NUM_PROCS) ? SIZE_W'(NUM_PROCS) : app_size_i;

  always_comb begin
    cmd_o.own     = req.own_rank;
    cmd_o.peer    = req.peer_rank;
    cmd_o.scan_n  = scan_n;
    cmd_o.any_tag = req.any_tag;
    cmd_o.tag     = req.msg_tag;
    cmd_o.dtype   = req.data_type;
    cmd_o.comm    = req.communicator;
    cmd_o.count   = req.elem_count;
    cmd_o.addr    = req.buffer_addr;
    if (req.cmd == CMD_SEND) begin
      cmd_o.op = (own_ok && peer_ok) ? OP_SEND : OP_BUSY;
    end else if (!own_ok) begin
      cmd_o.op = OP_PEND;
    end else if (req.any_source) begin
      if (req.own_rank != '0) begin
        cmd_o.op = OP_SCAN_S;
      end else begin
        cmd_o.op = (scan_n == '0) ? OP_PEND : OP_SCAN_M;
      end
    end else begin
      cmd_o.op = peer_ok ? OP_DIRECT : OP_PEND;
    end
  end

endmodule

/* src/mbx_fifo.sv */
// ----------------------------------------------------------------------------
// Mailbox work queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module mbx_fifo
  import mbx_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* src/mbx_back.sv */
// ----------------------------------------------------------------------------
// Mailbox back end
// Holds the slot table, executes sends and receives, drives results.
// ----------------------------------------------------------------------------
module mbx_back
  import mbx_pkg::*;
#(
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  cmd_t             q_data_i,
  output logic             pop_o,
  input  logic [TAG_W-1:0] tag_mask_i,
  mbx_rsp_if.source        rsp
);

  localparam int NSLOT = 3 * NUM_PROCS;
  localparam int SW    = $clog2(NSLOT);
  localparam logic [SW-1:0] BASE_S2M = SW'(NUM_PROCS);
  localparam logic [SW-1:0] BASE_S2S = SW'(2 * NUM_PROCS);

  back_state_e       state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [SW-1:0]     addr_q, addr_d;
  logic [SIZE_W-1:0] idx_q, idx_d;
  logic [NSLOT-1:0]  full_q, full_d;
  entry_t            mem [NSLOT];
  entry_t            rd_q;
  logic              mem_we;
  logic [SW-1:0]     send_slot;
  entry_t            wr_entry;
  status_e           chk;
  logic              hit;

  logic              ov_q, ov_d;
  status_e           st_q, st_d;
  logic [RANK_W-1:0] src_q, src_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [ADDR_W-1:0] maddr_q, maddr_d;

  assign rsp.valid        = ov_q;
  assign rsp.status_code  = st_q;
  assign rsp.source_rank  = src_q;
  assign rsp.matched_tag  = tag_q;
  assign rsp.message_addr = maddr_q;

  always_comb begin
    if (q_data_i.own == '0) begin
      send_slot = SW'(q_data_i.peer);
    end else if (q_data_i.peer == '0) begin
      send_slot = BASE_S2M + SW'(q_data_i.own);
    end else begin
      send_slot = BASE_S2S + SW'(q_data_i.peer);
    end
    wr_entry.source = q_data_i.own;
    wr_entry.dtype  = q_data_i.dtype;
    wr_entry.comm   = q_data_i.comm;
    wr_entry.tag    = q_data_i.tag;
    wr_entry.count  = q_data_i.count;
    wr_entry.addr   = q_data_i.addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[send_slot] <= wr_entry;
    end
    rd_q <= mem[addr_q];
  end

  assign chk = mbx_check(rd_q, cur_q, tag_mask_i);
  assign hit = full_q[addr_q] && (chk == ST_OK);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    addr_d  = addr_q;
    idx_d   = idx_q;
    full_d  = full_q;
    ov_d    = ov_q && !rsp.ready;
    st_d    = st_q;
    src_d   = src_q;
    tag_d   = tag_q;
    maddr_d = maddr_q;
    pop_o   = 1'b0;
    mem_we  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i && (!ov_q || rsp.ready)) begin
          pop_o   = 1'b1;
          cur_d   = q_data_i;
          idx_d   = '0;
          src_d   = '0;
          tag_d   = '0;
          maddr_d = '0;
          case (q_data_i.op)
            OP_SEND: begin
              ov_d = 1'b1;
              if (full_q[send_slot]) begin
                st_d = ST_BUSY;
              end else begin
                mem_we            = 1'b1;
                full_d[send_slot] = 1'b1;
                st_d              = ST_OK;
              end
            end
            OP_BUSY: begin
              ov_d = 1'b1;
              st_d = ST_BUSY;
            end
            OP_DIRECT: begin
              state_d = B_LOOK;
              if (q_data_i.peer == '0) begin
                addr_d = SW'(q_data_i.own);
              end else if (q_data_i.own == '0) begin
                addr_d = BASE_S2M + SW'(q_data_i.peer);
              end else begin
                addr_d = BASE_S2S + SW'(q_data_i.own);
              end
            end
            OP_SCAN_M: begin
              state_d = B_LOOK;
              addr_d  = BASE_S2M;
            end
            OP_SCAN_S: begin
              state_d = B_LOOK;
              addr_d  = SW'(q_data_i.own);
            end
            default: begin
              ov_d = 1'b1;
              st_d = ST_PENDING;
            end
          endcase
        end
      end
      B_LOOK: begin
        state_d = B_CHECK;
      end
      B_CHECK: begin
        state_d = B_IDLE;
        ov_d    = 1'b1;
        st_d    = ST_PENDING;
        case (cur_q.op)
          OP_DIRECT: begin
            if (full_q[addr_q] && !(cur_q.own != '0 && cur_q.peer != '0 &&
                                    rd_q.source != cur_q.peer)) begin
              st_d = chk;
              if (chk == ST_OK) begin
                src_d = cur_q.peer;
              end
            end
          end
          OP_SCAN_M: begin
            if (hit) begin
              st_d  = ST_OK;
              src_d = idx_q[RANK_W-1:0];
            end else if (idx_q + 1'b1 < cur_q.scan_n) begin
              ov_d    = 1'b0;
              state_d = B_LOOK;
              idx_d   = idx_q + 1'b1;
              addr_d  = BASE_S2M + SW'(idx_q + 1'b1);
            end
          end
          OP_SCAN_S: begin
            if (hit) begin
              st_d  = ST_OK;
              src_d = (idx_q == '0) ? '0 : rd_q.source;
            end else if (idx_q == '0) begin
              ov_d    = 1'b0;
              state_d = B_LOOK;
              idx_d   = SIZE_W'(1);
              addr_d  = BASE_S2S + SW'(cur_q.own);
            end
          end
          default: begin
          end
        endcase
        // take the slot on a match
        if (ov_d && st_d == ST_OK) begin
          full_d[addr_q] = 1'b0;
          tag_d          = rd_q.tag;
          maddr_d        = rd_q.addr;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    addr_q  <= addr_d;
    idx_q   <= idx_d;
    st_q    <= st_d;
    src_q   <= src_d;
    tag_q   <= tag_d;
    maddr_q <= maddr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      full_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
      ov_q    <= ov_d;
    end
  end

endmodule

/* src/mailbox_slot_message_matcher_unit.sv */
// ----------------------------------------------------------------------------
// Mailbox slot message matcher
// Per-processor mailbox slots: sends store headers, receives match and free.
// ----------------------------------------------------------------------------
//   channel  dir  handshake    contents
//   req      in   valid/ready  send or receive request
//   rsp      out  valid/ready  status, source, tag, address
//   cfg      in   cfg_we_i     application size, internal tag mask
//
// A send or an immediate answer is handled in the back end's idle state; a directed
// receive reads one slot; an any-source receive reads slots one at a time through
// the single read port of the slot table: up to application_size slots
// (clamped to NUM_PROCS) for rank 0 and up to two slots for any other rank.
// Reset clears all slot full marks at once. A two-entry queue keeps requests
// flowing while a result waits for rsp.ready.
// ----------------------------------------------------------------------------
module mailbox_slot_message_matcher_unit
  import mbx_pkg::*;
#(
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mbx_req_if.sink               req,
  mbx_rsp_if.source             rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [SIZE_W-1:0] app_size_q;
  logic [TAG_W-1:0]  tag_mask_q;
  logic              push, pop, q_full, q_empty;
  cmd_t              push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      app_size_q <= APP_SIZE_RST;
      tag_mask_q <= TAG_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_APP_SIZE: app_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_TAG_MASK: tag_mask_q <= cfg_data_i[TAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mbx_front #(.NUM_PROCS(NUM_PROCS)) u_front (
    .req        (req),
    .app_size_i (app_size_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mbx_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mbx_back #(.NUM_PROCS(NUM_PROCS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (head_cmd),
    .pop_o      (pop),
    .tag_mask_i (tag_mask_q),
    .rsp        (rsp)
  );

endmodule

/* tb/tb_mailbox_slot_message_matcher_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mailbox slot matcher testbench
// Drives send and receive items with random bursts and gaps and random
// result stalls. A mailbox table predicts each status item in order.
// ----------------------------------------------------------------------------
module tb_mailbox_slot_message_matcher_unit;
  import mbx_pkg::*;

  localparam int NP = 8;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  src;
    logic [15:0] tag;
    logic [31:0] addr;
  } mbx_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  mbx_req_if req ();
  mbx_rsp_if rsp ();

  mailbox_slot_message_matcher_unit #(.NUM_PROCS(NP)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predicted mailbox table
  logic        box_full [3*NP];
  logic [2:0]  box_src  [3*NP];
  logic [7:0]  box_type [3*NP];
  logic [7:0]  box_comm [3*NP];
  logic [15:0] box_tag  [3*NP];
  logic [15:0] box_cnt  [3*NP];
  logic [31:0] box_addr [3*NP];
  logic [3:0]  app_size;
  logic [15:0] tag_mask;

  mbx_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  logic stall_mode = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  function automatic status_e header_status(int s, logic at, logic [15:0] tg,
                                            logic [7:0] dt, logic [7:0] cm,
                                            logic [15:0] ct);
    if (box_type[s] != dt) return ST_TYPE;
    if (at ? ((box_tag[s] & tag_mask) == 16'd0) : (box_tag[s] != tg)) return ST_TAG;
    if (box_comm[s] != cm) return ST_COMM;
    if (box_cnt[s] != ct) return ST_COUNT;
    return ST_OK;
  endfunction

  function automatic mbx_result_t take_box(int s, logic [2:0] src);
    mbx_result_t r;
    r.status = ST_OK;
    r.src = src;
    r.tag = box_tag[s];
    r.addr = box_addr[s];
    box_full[s] = 1'b0;
    return r;
  endfunction

  function automatic mbx_result_t predict_mailbox(logic cmd, logic [2:0] own,
      logic [2:0] peer, logic asrc, logic [15:0] tg, logic at, logic [7:0] dt,
      logic [7:0] cm, logic [15:0] ct, logic [31:0] ad);
    mbx_result_t r;
    int s;
    int n;
    status_e st;
    r = '0;
    r.status = ST_PENDING;
    if (cmd == CMD_SEND) begin
      if (own == 0) s = peer;
      else if (peer == 0) s = NP + own;
      else s = 2*NP + peer;
      if (box_full[s]) begin
        r.status = ST_BUSY;
      end else begin
        box_full[s] = 1'b1; box_src[s] = own; box_type[s] = dt; box_comm[s] = cm;
        box_tag[s] = tg; box_cnt[s] = ct; box_addr[s] = ad;
        r.status = ST_OK;
      end
      return r;
    end
    if (asrc) begin
      if (own == 0) begin
        n = (app_size > NP) ? NP : app_size;
        for (int i = 0; i < n; i++) begin
          if (box_full[NP+i] && header_status(NP+i, at, tg, dt, cm, ct) == ST_OK)
            return take_box(NP+i, i[2:0]);
        end
      end else begin
        if (box_full[own] && header_status(own, at, tg, dt, cm, ct) == ST_OK)
          return take_box(own, 3'd0);
        s = 2*NP + own;
        if (box_full[s] && header_status(s, at, tg, dt, cm, ct) == ST_OK)
          return take_box(s, box_src[s]);
      end
      return r;
    end
    if (peer == 0) s = own;
    else if (own == 0) s = NP + peer;
    else s = 2*NP + own;
    if (!box_full[s]) return r;
    if (peer != 0 && own != 0 && box_src[s] != peer) return r;
    st = header_status(s, at, tg, dt, cm, ct);
    if (st != ST_OK) begin
      r.status = st;
      return r;
    end
    return take_box(s, peer);
  endfunction

  initial begin
    req.valid = 1'b0; req.cmd = 1'b0; req.own_rank = '0; req.peer_rank = '0;
    req.any_source = 1'b0; req.msg_tag = '0; req.any_tag = 1'b0;
    req.data_type = '0; req.communicator = '0; req.elem_count = '0;
    req.buffer_addr = '0;
    rsp.ready = 1'b0;
  end

  // result side: random stall pattern plus forced hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      rsp.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
    end
  end

  always @(posedge clk_i) begin
    mbx_result_t exp_r;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, rsp.status_code);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp.status_code !== exp_r.status || rsp.source_rank !== exp_r.src ||
            rsp.matched_tag !== exp_r.tag || rsp.message_addr !== exp_r.addr) begin
          $display({"%0t: mismatch expected st=%0d src=%0d tag=%h addr=%h",
                    " got st=%0d src=%0d tag=%h addr=%h"},
                   $time, exp_r.status, exp_r.src, exp_r.tag, exp_r.addr,
                   rsp.status_code, rsp.source_rank, rsp.matched_tag, rsp.message_addr);
          errors++;
        end
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_item(logic cmd, logic [2:0] own, logic [2:0] peer, logic asrc,
                           logic [15:0] tg, logic at, logic [7:0] dt, logic [7:0] cm,
                           logic [15:0] ct, logic [31:0] ad);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
      burst_left = $urandom_range(1, 20);
      if (gap_left > 0) begin
        req.valid <= 1'b0;
        repeat (gap_left) @(posedge clk_i);
      end
    end
    burst_left--;
    req.valid <= 1'b1; req.cmd <= cmd; req.own_rank <= own; req.peer_rank <= peer;
    req.any_source <= asrc; req.msg_tag <= tg; req.any_tag <= at;
    req.data_type <= dt; req.communicator <= cm; req.elem_count <= ct;
    req.buffer_addr <= ad;
    pending_results.push_back(predict_mailbox(cmd, own, peer, asrc, tg, at, dt, cm, ct, ad));
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain_and_idle();
    req.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_APP_SIZE) app_size = val[3:0];
    else tag_mask = val;
  endtask

  task automatic test_directed();
    // send/receive round trips at field extremes
    send_item(CMD_SEND, 0, 7, 0, 16'hFFFF, 0, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFFFFFF);
    send_item(CMD_SEND, 0, 7, 0, 16'h0, 0, 8'h0, 8'h0, 16'h0, 32'h0);
    send_item(CMD_RECV, 7, 0, 0, 16'hFFFF, 0, 8'hFE, 8'hFF, 16'hFFFF, 0);
    send_item(CMD_RECV, 7, 0, 0, 16'hFFFE, 0, 8'hFF, 8'hFF, 16'hFFFF, 0);
    send_item(CMD_RECV, 7, 0, 0, 16'hFFFF, 0, 8'hFF, 8'hFE, 16'hFFFF, 0);
    send_item(CMD_RECV, 7, 0, 0, 16'hFFFF, 0, 8'hFF, 8'hFF, 16'hFFFE, 0);
    send_item(CMD_RECV, 7, 0, 0, 16'hFFFF, 0, 8'hFF, 8'hFF, 16'hFFFF, 0);
    send_item(CMD_RECV, 7, 0, 0, 16'hFFFF, 0, 8'hFF, 8'hFF, 16'hFFFF, 0);
    // slave to master, master any-source with any-tag
    send_item(CMD_SEND, 3, 0, 0, 16'h8001, 0, 8'h11, 8'h22, 16'h5, 32'h0);
    send_item(CMD_RECV, 0, 3, 0, 16'h0, 1, 8'h11, 8'h22, 16'h5, 0);
    send_item(CMD_RECV, 0, 0, 1, 16'h0, 1, 8'h11, 8'h22, 16'h5, 0);
    send_item(CMD_SEND, 3, 0, 0, 16'h0001, 0, 8'h11, 8'h22, 16'h5, 32'h1234);
    send_item(CMD_RECV, 0, 0, 1, 16'h0, 1, 8'h11, 8'h22, 16'h5, 0);
    send_item(CMD_RECV, 0, 3, 0, 16'h1, 0, 8'h11, 8'h22, 16'h5, 0);
    // slave to slave, wrong source then right
    send_item(CMD_SEND, 2, 5, 0, 16'h77, 0, 8'h1, 8'h2, 16'h3, 32'hA5A5A5A5);
    send_item(CMD_SEND, 4, 5, 0, 16'h77, 0, 8'h1, 8'h2, 16'h3, 32'h1);
    send_item(CMD_RECV, 5, 4, 0, 16'h77, 0, 8'h1, 8'h2, 16'h3, 0);
    send_item(CMD_RECV, 5, 0, 1, 16'h77, 0, 8'h1, 8'h2, 16'h3, 0);
    // master to itself, slave any-source on master slot
    send_item(CMD_SEND, 0, 0, 0, 16'h9, 0, 8'h9, 8'h9, 16'h9, 32'h9);
    send_item(CMD_RECV, 0, 0, 0, 16'h9, 0, 8'h9, 8'h9, 16'h9, 0);
    send_item(CMD_SEND, 0, 6, 0, 16'h9, 0, 8'h9, 8'h9, 16'h9, 32'h9);
    send_item(CMD_RECV, 6, 3, 1, 16'h9, 0, 8'h9, 8'h9, 16'h9, 0);
    drain_and_idle();
  endtask

  task automatic random_traffic(int count);
    logic [2:0] own, peer;
    logic [7:0] dt, cm;
    logic [15:0] tg, ct;
    for (int i = 0; i < count; i++) begin
      own = 3'($urandom_range(0, 7));
      peer = 3'($urandom_range(0, 7));
      // small header alphabet so receives often match
      dt = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      cm = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      ct = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
      tg = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
           {1'($urandom_range(0, 1)), 14'd0, 1'($urandom_range(0, 1))};
      if (i == count / 3) hold_off = 400;
      send_item(1'($urandom_range(0, 1)), own, peer, $urandom_range(0, 2) == 0, tg,
                $urandom_range(0, 2) == 0, dt, cm, ct, $urandom);
    end
    drain_and_idle();
  endtask

  initial begin
    for (int i = 0; i < 3*NP; i++) box_full[i] = 1'b0;
    app_size = APP_SIZE_RST;
    tag_mask = TAG_MASK_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    random_traffic(700);
    write_reg(REG_APP_SIZE, 16'd15);
    write_reg(REG_TAG_MASK, 16'hFFFF);
    random_traffic(500);
    write_reg(REG_APP_SIZE, 16'd0);
    write_reg(REG_TAG_MASK, 16'h0000);
    random_traffic(300);
    write_reg(REG_APP_SIZE, 16'd1);
    write_reg(REG_TAG_MASK, 16'h0001);
    random_traffic(300);
    write_reg(REG_APP_SIZE, 16'd4);
    write_reg(REG_TAG_MASK, 16'h8000);
    random_traffic(300);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
